// ===== rtl/core/mgfb_pkg.sv =====
package mgfb_pkg;

    // Item kinds carried on the input channel
    typedef enum logic [2:0] {
        KIND_DRAW     = 3'd0,
        KIND_REVERSED = 3'd1,
        KIND_XOR      = 3'd2,
        KIND_FILL     = 3'd3,
        KIND_READ     = 3'd4
    } t_kind;

    // Rotation register codes
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DRAW,
        ST_READ
    } t_state;

    // Most pixels a single glyph byte can carry
    localparam logic [3:0] BIT_COUNT_MAX = 4'd8;

    // Row within a page: the low bits of a screen row
    localparam logic [7:0] PAGE_ROW_MASK = 8'h07;

endpackage

// ===== rtl/core/mono_glyph_framebuffer_blitter.sv =====
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-----------------------------------------
// input     | i_in_valid / o_in_stall       | i_kind .. i_read_page, one port per field
// output    | o_out_valid / i_out_stall     | o_read_byte
// config    | i_cfg_we (no wait)            | i_cfg_data (rotation)
//
// A draw item loads its item registers, then the glyph byte shifts out MSB first, one
// pixel read-modify-write per cycle through the single frame store port pair. A read
// item waits in ST_READ for the output slot, then its byte passes the registered read
// and the write stage into o_read_byte. A fill item sweeps the store one byte a cycle.
// After reset the same sweep clears the store to zero; o_in_stall stays high meanwhile.
// A waiting result only holds back the next read item, never a draw or fill item.
module mono_glyph_framebuffer_blitter #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_base_x,
    input  logic [7:0] i_base_y,
    input  logic [4:0] i_glyph_row,
    input  logic [4:0] i_glyph_col,
    input  logic [7:0] i_glyph_bits,
    input  logic [3:0] i_bit_count,
    input  logic [6:0] i_read_column,
    input  logic [2:0] i_read_page,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_byte
);

    localparam int PAGE_COUNT = SCREEN_HEIGHT / 8;
    localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam logic [7:0]        W_M1      = 8'(SCREEN_WIDTH - 1);
    localparam logic [7:0]        H_M1      = 8'(SCREEN_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

    // Control state
    mgfb_pkg::t_state r_state, n_state;
    mgfb_pkg::t_rot   r_rot;
    logic [ADDR_W-1:0] r_sweep;
    logic [3:0]        r_left;

    // Item registers
    mgfb_pkg::t_kind r_kind;
    logic [7:0] r_gx, r_gy, r_bits, r_fill;
    logic [6:0] r_rcol;
    logic [2:0] r_rpage;

    // Pixel write stage
    logic              r_s1_valid, r_s1_read, r_s1_zero, r_s1_on;
    mgfb_pkg::t_kind   r_s1_kind;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [7:0]        r_s1_mask, r_rd_data;

    // Last pixel write, forwarded over the stale read
    logic              r_fw_valid;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [7:0]        r_fw_data;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;

    logic [7:0] mem_frame [STORE_SIZE];

    logic              in_acc, issue, pix_in, rd_in, sweep_we, pix_we;
    logic [3:0]        eff_count;
    logic [7:0]        px, py, base_byte, new_byte, wr_data;
    logic [ADDR_W-1:0] pix_addr, rd_addr, wr_addr, iss_addr;

    assign in_acc    = i_in_valid && (r_state == mgfb_pkg::ST_IDLE);
    assign eff_count = (i_bit_count > mgfb_pkg::BIT_COUNT_MAX) ? mgfb_pkg::BIT_COUNT_MAX
                                                                : i_bit_count;

    // Map the current glyph pixel through the rotation
    always_comb begin
        unique case (r_rot)
            mgfb_pkg::ROT_0: begin
                px = r_gx;
                py = r_gy;
            end
            mgfb_pkg::ROT_90: begin
                px = r_gy;
                py = H_M1 - r_gx;
            end
            mgfb_pkg::ROT_180: begin
                px = W_M1 - r_gx;
                py = H_M1 - r_gy;
            end
            mgfb_pkg::ROT_270: begin
                px = W_M1 - r_gy;
                py = r_gx;
            end
            default: begin
                px = r_gx;
                py = r_gy;
            end
        endcase
    end

    assign pix_in   = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT));
    assign pix_addr = ADDR_W'(32'(px) * PAGE_COUNT + 32'(py[7:3]));
    assign rd_in    = ({1'b0, r_rcol} < 8'(SCREEN_WIDTH)) && (32'(r_rpage) < PAGE_COUNT);
    assign rd_addr  = rd_in ? ADDR_W'(32'(r_rcol) * PAGE_COUNT + 32'(r_rpage)) : '0;

    // Sequencer: next state and issue control
    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        sweep_we = 1'b0;
        unique case (r_state)
            mgfb_pkg::ST_SWEEP: begin
                sweep_we = 1'b1;
                if (r_sweep == LAST_ADDR) n_state = mgfb_pkg::ST_IDLE;
            end
            mgfb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (mgfb_pkg::t_kind'(i_kind))
                        mgfb_pkg::KIND_DRAW, mgfb_pkg::KIND_REVERSED,
                        mgfb_pkg::KIND_XOR: begin
                            if (eff_count != 4'd0) n_state = mgfb_pkg::ST_DRAW;
                        end
                        mgfb_pkg::KIND_FILL: n_state = mgfb_pkg::ST_SWEEP;
                        mgfb_pkg::KIND_READ: n_state = mgfb_pkg::ST_READ;
                        default: n_state = mgfb_pkg::ST_IDLE;
                    endcase
                end
            end
            mgfb_pkg::ST_DRAW: begin
                issue = 1'b1;
                if (r_left == 4'd1) n_state = mgfb_pkg::ST_IDLE;
            end
            mgfb_pkg::ST_READ: begin
                // wait until the output slot is free by the time the byte arrives
                if (!r_out_valid || !i_out_stall) begin
                    issue   = 1'b1;
                    n_state = mgfb_pkg::ST_IDLE;
                end
            end
            default: n_state = mgfb_pkg::ST_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mgfb_pkg::ST_SWEEP;
        else          r_state <= n_state;
    end

    assign iss_addr = (r_state == mgfb_pkg::ST_READ) ? rd_addr : pix_addr;

    // Modify the byte read for the pixel in the write stage
    assign base_byte = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_rd_data;

    always_comb begin
        if (r_s1_kind == mgfb_pkg::KIND_XOR) begin
            new_byte = r_s1_on ? (base_byte ^ r_s1_mask) : base_byte;
        end else if (r_s1_on ^ (r_s1_kind == mgfb_pkg::KIND_REVERSED)) begin
            new_byte = base_byte | r_s1_mask;
        end else begin
            new_byte = base_byte & ~r_s1_mask;
        end
    end

    assign pix_we  = r_s1_valid && !r_s1_read;
    assign wr_addr = sweep_we ? r_sweep : r_s1_addr;
    assign wr_data = sweep_we ? r_fill : new_byte;

    // Frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (sweep_we || pix_we) mem_frame[wr_addr] <= wr_data;
        if (issue)              r_rd_data <= mem_frame[iss_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot       <= mgfb_pkg::ROT_0;
            r_sweep     <= '0;
            r_fill      <= 8'h00;
            r_left      <= 4'd0;
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_rot <= mgfb_pkg::t_rot'(i_cfg_data);

            // advance the sweep, restart it for a fill item
            if (sweep_we) r_sweep <= r_sweep + ADDR_W'(1);
            if (in_acc && (mgfb_pkg::t_kind'(i_kind) == mgfb_pkg::KIND_FILL)) begin
                r_sweep <= '0;
                r_fill  <= i_glyph_bits;
            end

            if (in_acc)                              r_left <= eff_count;
            else if (r_state == mgfb_pkg::ST_DRAW)   r_left <= r_left - 4'd1;

            r_s1_valid <= issue && ((r_state == mgfb_pkg::ST_READ) || pix_in);
            r_fw_valid <= pix_we;

            // drop the result once taken, load a fresh one from the read stage
            if (r_s1_valid && r_s1_read)   r_out_valid <= 1'b1;
            else if (!i_out_stall)         r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= mgfb_pkg::t_kind'(i_kind);
            r_gx    <= i_base_x + 8'(i_glyph_col);
            r_gy    <= i_base_y + 8'(i_glyph_row);
            r_bits  <= i_glyph_bits;
            r_rcol  <= i_read_column;
            r_rpage <= i_read_page;
        end else if (r_state == mgfb_pkg::ST_DRAW) begin
            // shift the next glyph bit up and step along the glyph row
            r_gx   <= r_gx + 8'd1;
            r_bits <= {r_bits[6:0], 1'b0};
        end
        if (issue) begin
            r_s1_read <= (r_state == mgfb_pkg::ST_READ);
            r_s1_zero <= !rd_in;
            r_s1_kind <= r_kind;
            r_s1_on   <= r_bits[7];
            r_s1_addr <= iss_addr;
            r_s1_mask <= 8'(8'd1 << (py & mgfb_pkg::PAGE_ROW_MASK));
        end
        if (pix_we) begin
            r_fw_addr <= r_s1_addr;
            r_fw_data <= new_byte;
        end
        if (r_s1_valid && r_s1_read) r_out_byte <= r_s1_zero ? 8'h00 : base_byte;
    end

    assign o_in_stall  = (r_state != mgfb_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_out_byte;

endmodule

// ===== rtl/core/mgfb_checker.sv =====
module mgfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_data,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_kind,
    input logic [7:0] i_base_x,
    input logic [7:0] i_base_y,
    input logic [4:0] i_glyph_row,
    input logic [4:0] i_glyph_col,
    input logic [7:0] i_glyph_bits,
    input logic [3:0] i_bit_count,
    input logic [6:0] i_read_column,
    input logic [2:0] i_read_page,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_read_byte
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_byte)))
        else $error("stalled result transaction changed");

    // Reset starts the clearing sweep, so no transaction is taken
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken right after reset");

    // A fill transaction blocks the input for its sweep
    a_fill_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == mgfb_pkg::KIND_FILL)) |=> ##1 o_in_stall)
        else $error("fill sweep ended too early");

    // A read transaction blocks the input for its issue cycle
    a_read_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == mgfb_pkg::KIND_READ)) |=> o_in_stall)
        else $error("read transaction not held for issue");

endmodule

bind mono_glyph_framebuffer_blitter mgfb_checker u_mgfb_checker (.*);

// ===== tb/sv/mono_glyph_framebuffer_blitter_tb.sv =====
package mgfb_tb_pkg;
    import mgfb_pkg::*;

    // Screen size shared by the shadow store and the bench
    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 64;

    // One transaction on the input channel, one field per port
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] base_x;
        logic [7:0] base_y;
        logic [4:0] glyph_row;
        logic [4:0] glyph_col;
        logic [7:0] glyph_bits;
        logic [3:0] bit_count;
        logic [6:0] read_column;
        logic [2:0] read_page;
    } t_glyph_item;

    // Shadow framebuffer plus the read-back bytes still owed by the block
    class framebuffer_scoreboard;
        localparam int WIDTH  = FB_WIDTH;
        localparam int HEIGHT = FB_HEIGHT;
        localparam int PAGES  = HEIGHT / 8;

        logic [7:0]  frame_bytes [WIDTH * PAGES];
        logic [7:0]  expected_bytes [$];
        t_rot        rotation;
        int unsigned errors;
        int unsigned reads_checked;
        logic [6:0]  last_column;
        logic [2:0]  last_page;

        function new();
            foreach (frame_bytes[j]) frame_bytes[j] = 8'h00;
            rotation      = ROT_0;
            errors        = 0;
            reads_checked = 0;
            last_column   = '0;
            last_page     = '0;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // Count a failure; only the first few are worth printing
        function void log_failure(string msg);
            errors++;
            if (errors <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        // Apply an accepted transaction to the shadow store
        function void record_item(t_glyph_item it);
            logic [7:0]  gx;
            logic [7:0]  gy;
            logic [7:0]  px;
            logic [7:0]  py;
            logic [7:0]  mask;
            logic        lit;
            int unsigned count;
            int unsigned slot;
            case (it.kind)
                KIND_DRAW, KIND_REVERSED, KIND_XOR: begin
                    count = (it.bit_count > BIT_COUNT_MAX) ? int'(BIT_COUNT_MAX)
                                                           : int'(it.bit_count);
                    gy = it.base_y + 8'(it.glyph_row);
                    for (int i = 0; i < int'(count); i++) begin
                        // Glyph coordinates wrap at 8 bits before and after rotation
                        gx = it.base_x + 8'(it.glyph_col) + 8'(i);
                        case (rotation)
                            ROT_0: begin
                                px = gx;
                                py = gy;
                            end
                            ROT_90: begin
                                px = gy;
                                py = 8'(HEIGHT - 1 - int'(gx));
                            end
                            ROT_180: begin
                                px = 8'(WIDTH - 1 - int'(gx));
                                py = 8'(HEIGHT - 1 - int'(gy));
                            end
                            default: begin
                                px = 8'(WIDTH - 1 - int'(gy));
                                py = gx;
                            end
                        endcase
                        lit = it.glyph_bits[7 - i];
                        // Drop pixels that fall off the screen
                        if (int'(px) < WIDTH && int'(py) < HEIGHT) begin
                            slot = int'(px) * PAGES + int'(py >> 3);
                            mask = 8'h01 << (py & PAGE_ROW_MASK);
                            if (it.kind == KIND_XOR) begin
                                if (lit) frame_bytes[slot] ^= mask;
                            end else if (lit ^ (it.kind == KIND_REVERSED)) begin
                                frame_bytes[slot] |= mask;
                            end else begin
                                frame_bytes[slot] &= ~mask;
                            end
                            last_column = px[6:0];
                            last_page   = py[5:3];
                        end
                    end
                end
                KIND_FILL: begin
                    foreach (frame_bytes[j]) frame_bytes[j] = it.glyph_bits;
                end
                KIND_READ: begin
                    if (int'(it.read_column) < WIDTH && int'(it.read_page) < PAGES) begin
                        expected_bytes.push_back(
                            frame_bytes[int'(it.read_column) * PAGES + int'(it.read_page)]);
                    end else begin
                        expected_bytes.push_back(8'h00);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare a returned byte against the oldest outstanding read
        function void check_read_byte(logic [7:0] got);
            logic [7:0] want;
            reads_checked++;
            if (expected_bytes.size() == 0) begin
                log_failure($sformatf("read-back %02h with no read outstanding", got));
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    log_failure($sformatf("read_byte mismatch: expected %02h, got %02h",
                                          want, got));
            end
        endfunction
    endclass

endpackage

module mono_glyph_framebuffer_blitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgfb_pkg::*;
    import mgfb_tb_pkg::*;

    localparam int SCREEN_WIDTH    = FB_WIDTH;
    localparam int SCREEN_HEIGHT   = FB_HEIGHT;
    localparam int CLK_PERIOD      = 10;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 270;
    // A fill sweeps the whole store, the slowest thing the block does
    localparam int SETTLE_CYCLES   = SCREEN_WIDTH * SCREEN_HEIGHT / 8 + 16;
    localparam int WATCHDOG_LIMIT  = 10 * SETTLE_CYCLES;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [1:0] i_cfg_data    = ROT_0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_kind        = KIND_DRAW;
    logic [7:0] i_base_x      = '0;
    logic [7:0] i_base_y      = '0;
    logic [4:0] i_glyph_row   = '0;
    logic [4:0] i_glyph_col   = '0;
    logic [7:0] i_glyph_bits  = '0;
    logic [3:0] i_bit_count   = '0;
    logic [6:0] i_read_column = '0;
    logic [2:0] i_read_page   = '0;
    logic       o_out_valid;
    logic       i_out_stall   = 1'b0;
    logic [7:0] o_read_byte;

    bit          idling_on = 1'b1;
    int unsigned out_stall_left;
    int unsigned quiet_cycles;
    int unsigned items_done;
    int unsigned rotations_used;
    int unsigned fills_done;

    mgfb_tb_pkg::framebuffer_scoreboard fb_model = new();

    mono_glyph_framebuffer_blitter #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_base_x      (i_base_x),
        .i_base_y      (i_base_y),
        .i_glyph_row   (i_glyph_row),
        .i_glyph_col   (i_glyph_col),
        .i_glyph_bits  (i_glyph_bits),
        .i_bit_count   (i_bit_count),
        .i_read_column (i_read_column),
        .i_read_page   (i_read_page),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_byte   (o_read_byte)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hold off the result channel in random bursts
    always @(posedge i_clk) begin
        if (out_stall_left == 0 && idling_on && $urandom_range(0, 6) == 0)
            out_stall_left = $urandom_range(1, 8);
        i_out_stall <= (out_stall_left != 0);
        if (out_stall_left != 0)
            out_stall_left = out_stall_left - 1;
    end

    // Check every read-back transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            fb_model.check_read_byte(o_read_byte);
    end

    // Count cycles in which no transaction moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("block went quiet for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_glyph_item random_fields();
        t_glyph_item it;
        it.kind        = 3'($urandom);
        it.base_x      = 8'($urandom);
        it.base_y      = 8'($urandom);
        it.glyph_row   = 5'($urandom);
        it.glyph_col   = 5'($urandom);
        it.glyph_bits  = 8'($urandom);
        it.bit_count   = 4'($urandom);
        it.read_column = 7'($urandom);
        it.read_page   = 3'($urandom);
        return it;
    endfunction

    function automatic t_glyph_item make_glyph(logic [2:0] kind, logic [7:0] bx,
                                               logic [7:0] by, logic [4:0] row,
                                               logic [4:0] col, logic [7:0] bits,
                                               logic [3:0] count);
        t_glyph_item it;
        it            = random_fields();
        it.kind       = kind;
        it.base_x     = bx;
        it.base_y     = by;
        it.glyph_row  = row;
        it.glyph_col  = col;
        it.glyph_bits = bits;
        it.bit_count  = count;
        return it;
    endfunction

    function automatic t_glyph_item read_at(logic [6:0] column, logic [2:0] page);
        t_glyph_item it;
        it             = random_fields();
        it.kind        = KIND_READ;
        it.read_column = column;
        it.read_page   = page;
        return it;
    endfunction

    // Mostly reads and stray draws, with the odd fill and unused kind
    function automatic t_glyph_item noise_item();
        t_glyph_item it;
        int unsigned pick;
        it   = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.kind = KIND_READ;
        else if (pick < 42)
            it.kind = KIND_FILL;
        else if (pick < 50)
            it.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        else
            it.kind = 3'($urandom_range(KIND_DRAW, KIND_XOR));
        // Aim half the reads at the last pixel touched
        if (pick < 20) begin
            it.read_column = fb_model.last_column;
            it.read_page   = fb_model.last_page;
        end
        return it;
    endfunction

    // Present one transaction and hold it until accepted
    task automatic drive_item(input t_glyph_item it);
        i_in_valid    <= 1'b1;
        i_kind        <= it.kind;
        i_base_x      <= it.base_x;
        i_base_y      <= it.base_y;
        i_glyph_row   <= it.glyph_row;
        i_glyph_col   <= it.glyph_col;
        i_glyph_bits  <= it.glyph_bits;
        i_bit_count   <= it.bit_count;
        i_read_column <= it.read_column;
        i_read_page   <= it.read_page;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        fb_model.record_item(it);
        if (it.kind <= KIND_READ) items_done++;
        if (it.kind == KIND_FILL) fills_done++;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic write_rotation(input t_rot rot);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= rot;
        @(posedge i_clk);
        fb_model.rotation = rot;
        i_cfg_we <= 1'b0;
        rotations_used++;
    endtask

    // Drain outstanding reads, then give a trailing fill time to finish
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (fb_model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Blit a whole glyph row by row, reading back as it goes
    task automatic draw_glyph();
        t_glyph_item it;
        logic [7:0]  bx;
        logic [7:0]  by;
        logic [2:0]  mode;
        int unsigned columns;
        int unsigned rows;
        int unsigned tail_count;
        int unsigned pick;
        bx   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        by   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        mode = (pick < 6) ? KIND_DRAW : (pick < 8) ? KIND_REVERSED : KIND_XOR;
        columns    = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(1, 2);
        rows       = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 16);
        tail_count = $urandom_range(1, 8);
        for (int r = 0; r < int'(rows); r++) begin
            for (int c = 0; c < int'(columns); c++) begin
                it = make_glyph(mode, bx, by, 5'(r), 5'(c * 8), 8'($urandom),
                                (c == int'(columns) - 1) ? 4'(tail_count) : BIT_COUNT_MAX);
                drive_item(it);
            end
            if ($urandom_range(0, 3) == 0)
                drive_item(read_at(fb_model.last_column, fb_model.last_page));
        end
        drive_item(read_at(fb_model.last_column, fb_model.last_page));
    endtask

    initial begin
        int unsigned phase_start;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_rotation(ROT_0);

        // Directed opening: corners, wrap-around, odd counts, every kind
        drive_item(read_at(0, 0));
        drive_item(make_glyph(KIND_DRAW, 0, 0, 0, 0, 8'hFF, 8));
        drive_item(read_at(3, 0));
        drive_item(make_glyph(KIND_REVERSED, 120, 63, 0, 0, 8'hF0, 8));
        drive_item(read_at(127, 7));
        drive_item(make_glyph(KIND_XOR, 120, 63, 0, 0, 8'hAA, 8));
        drive_item(read_at(126, 7));
        drive_item(make_glyph(KIND_DRAW, 10, 10, 0, 0, 8'hFF, 0));
        drive_item(make_glyph(KIND_DRAW, 20, 20, 0, 3, 8'hFF, 15));
        drive_item(read_at(23, 2));
        drive_item(make_glyph(KIND_DRAW, 255, 255, 31, 31, 8'hFF, 8));
        drive_item(read_at(30, 3));
        drive_item(make_glyph(KIND_SPARE_FIRST, 23, 16, 4, 0, 8'h00, 8));
        drive_item(make_glyph(KIND_SPARE_LAST, 23, 16, 4, 0, 8'h00, 8));
        drive_item(read_at(23, 2));
        drive_item(make_glyph(KIND_FILL, 0, 0, 0, 0, 8'h5A, 8));
        drive_item(read_at(127, 7));
        drive_item(read_at(0, 0));
        drive_item(make_glyph(KIND_FILL, 0, 0, 0, 0, 8'hFF, 8));
        drive_item(read_at(64, 4));
        drive_item(make_glyph(KIND_FILL, 0, 0, 0, 0, 8'h00, 8));
        drive_item(read_at(64, 4));
        settle_block();

        // Random phases, one rotation each; the last runs without idling
        for (int phase = 0; phase < PHASES; phase++) begin
            idling_on = (phase != PHASES - 1);
            write_rotation((phase < PHASES - 2) ? t_rot'((phase + 1) % 4)
                                                : t_rot'($urandom_range(0, 3)));
            phase_start = items_done;
            while (items_done - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 4) == 0)
                    draw_glyph();
                else
                    drive_item(noise_item());
            end
            settle_block();
        end

        $display("Covered %0d transactions (%0d fills) over %0d rotation writes;",
                 items_done, fills_done, rotations_used);
        $display("checked %0d read-back bytes, %0d failures.",
                 fb_model.reads_checked, fb_model.errors);
        if (fb_model.errors == 0 && fb_model.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
